// ===== sv/bdrgc_pkg.sv =====
`timescale 1ns / 1ps

package bdrgc_pkg;

    localparam int BLOCK_MAX = 64;
    localparam int ADDR_W    = $clog2(BLOCK_MAX);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 22;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int LEVEL_W   = 15;
    localparam int SCALE_W   = 9;
    localparam int PROD_W    = SAMPLE_W + SCALE_W + 1;
    localparam int GATED_W   = PROD_W - 8;
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 15;

    localparam logic [IDX_W-1:0] REG_GATE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_GATE_SCALE     = 2'd1;
    localparam logic [IDX_W-1:0] REG_CLIP_LEVEL     = 2'd2;

    localparam logic [LEVEL_W-1:0] GATE_THRESHOLD_RST = 15'd33;
    localparam logic [SCALE_W-1:0] GATE_SCALE_RST     = 9'd26;
    localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RST     = 15'd31130;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_last;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       out_last;
        logic                       forced_end;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIVGO,
        ST_DIV,
        ST_DRAIN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic rd_step;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_next;
        logic div_done;
        logic rd_last;
        logic pipe_idle;
    } dp_status_t;

endpackage

// ===== sv/block_dc_remove_gate_clip_core.sv =====
`timescale 1ns / 1ps
// Loading accepts one sample per cycle while start is high; busy stays low until a
// block ends. After the final sample the controller launches the mean, a restoring
// divider makes one quotient bit per cycle, and the mean is latched; the results
// then follow one per cycle. busy stays high until the last result has left the
// output register; results cannot be stalled.
// Reset clears the sum, count and state and loads the register defaults.
module block_dc_remove_gate_clip_core
    import bdrgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sample_item_t       sample_item,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_index,
    input  logic [DATA_W-1:0]  wr_data,
    output logic               valid,
    output result_item_t       result_item
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bdrgc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .block_last (sample_item.block_last),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    bdrgc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample_item (sample_item),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .valid       (valid),
        .result_item (result_item)
    );

endmodule

// ===== sv/bdrgc_div.sv =====
`timescale 1ns / 1ps

module bdrgc_div
    import bdrgc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    dividend,
    input  logic        [CNT_W-1:0]    divisor,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W:0]       rem_shift;
    logic [SUM_W-1:0]     q_signed;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_shift = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        if (start)
        begin
            run_next  = 1'b1;
            neg_next  = dividend[SUM_W-1];
            dvd_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
        end
        else if (run_reg)
        begin
            // one restoring step: quotient bits shift in at the bottom
            if (rem_shift >= {1'b0, dsr_reg})
            begin
                rem_next = rem_shift - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign q_signed = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign quotient = q_signed[SAMPLE_W-1:0];
    assign done     = done_reg;

endmodule

// ===== sv/bdrgc_dp.sv =====
`timescale 1ns / 1ps

module bdrgc_dp
    import bdrgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  sample_item_t       sample_item,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_index,
    input  logic [DATA_W-1:0]  wr_data,
    output logic               valid,
    output result_item_t       result_item
);

    logic signed [SAMPLE_W-1:0] mem [BLOCK_MAX];

    logic [LEVEL_W-1:0]          thr_reg;
    logic [SCALE_W-1:0]          scale_reg;
    logic [LEVEL_W-1:0]          clip_reg;

    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ADDR_W-1:0]           ptr_reg, ptr_next;
    logic                        forced_reg;
    logic signed [SAMPLE_W-1:0]  mean_reg;

    logic                        div_done;
    logic signed [SAMPLE_W-1:0]  div_q;

    logic                        rv_reg, rl_reg;
    logic signed [SAMPLE_W-1:0]  rd_reg;
    logic                        v1_reg, l1_reg, g1_reg;
    logic signed [SAMPLE_W-1:0]  c1_reg;
    logic                        v2_reg, l2_reg;
    logic signed [GATED_W-1:0]   g2_reg;
    logic                        valid_reg;
    result_item_t                result_reg;

    logic signed [SAMPLE_W:0]    diff;
    logic signed [SAMPLE_W-1:0]  c_sat;
    logic [SAMPLE_W:0]           mag;
    logic signed [PROD_W-1:0]    prod;
    logic signed [GATED_W-1:0]   gated;
    logic signed [GATED_W-1:0]   lim_pos, lim_neg;
    logic signed [SAMPLE_W-1:0]  clamped;
    logic                        rd_last_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= GATE_THRESHOLD_RST;
            scale_reg <= GATE_SCALE_RST;
            clip_reg  <= CLIP_LEVEL_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GATE_THRESHOLD: thr_reg   <= wr_data[LEVEL_W-1:0];
                REG_GATE_SCALE:     scale_reg <= wr_data[SCALE_W-1:0];
                REG_CLIP_LEVEL:     clip_reg  <= wr_data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (cmd.clear)
        begin
            sum_next = '0;
            cnt_next = '0;
            ptr_next = '0;
        end
        else
        begin
            if (cmd.load)
            begin
                sum_next = sum_reg + SUM_W'(sample_item.sample_in);
                cnt_next = cnt_reg + 1'b1;
            end
            if (cmd.rd_step)
                ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= sample_item.sample_in;
            forced_reg               <= ~sample_item.block_last;
        end
        if (cmd.rd_step)
            rd_reg <= mem[ptr_reg];
        if (div_done)
            mean_reg <= div_q;
    end

    bdrgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_last_now = ({1'b0, ptr_reg} + 1'b1) == cnt_reg;

    // center with saturation and test the gate
    always_comb
    begin
        diff = {rd_reg[SAMPLE_W-1], rd_reg} - {mean_reg[SAMPLE_W-1], mean_reg};
        if (diff > $signed({2'b00, {(SAMPLE_W-1){1'b1}}}))
            c_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (diff < $signed({2'b11, {(SAMPLE_W-1){1'b0}}}))
            c_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            c_sat = diff[SAMPLE_W-1:0];
        mag = c_sat[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({c_sat[SAMPLE_W-1], c_sat}))
                                : {1'b0, c_sat};
    end

    assign prod  = PROD_W'(c1_reg) * PROD_W'($signed({1'b0, scale_reg}));
    assign gated = g1_reg ? prod[PROD_W-1:8] : GATED_W'(c1_reg);

    assign lim_pos = $signed({{(GATED_W-LEVEL_W){1'b0}}, clip_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (g2_reg > lim_pos)
            clamped = lim_pos[SAMPLE_W-1:0];
        else if (g2_reg < lim_neg)
            clamped = lim_neg[SAMPLE_W-1:0];
        else
            clamped = g2_reg[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            rv_reg    <= cmd.rd_step;
            v1_reg    <= rv_reg;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rl_reg                <= rd_last_now;
        l1_reg                <= rl_reg;
        c1_reg                <= c_sat;
        g1_reg                <= mag < {2'b00, thr_reg};
        l2_reg                <= l1_reg;
        g2_reg                <= gated;
        result_reg.sample_out <= clamped;
        result_reg.out_last   <= l2_reg;
        result_reg.forced_end <= forced_reg;
    end

    assign status.fill_next = cnt_reg == CNT_W'(BLOCK_MAX - 1);
    assign status.div_done  = div_done;
    assign status.rd_last   = rd_last_now;
    assign status.pipe_idle = ~(rv_reg | v1_reg | v2_reg | valid_reg);

    assign valid       = valid_reg;
    assign result_item = result_reg;

endmodule

// ===== sv/bdrgc_ctrl.sv =====
`timescale 1ns / 1ps

module bdrgc_ctrl
    import bdrgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         block_last,
    input  dp_status_t   status,
    output dp_cmd_t      cmd,
    output logic         busy
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (block_last || status.fill_next)
                        state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.rd_step = 1'b1;
                if (status.rd_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                // hold until the last sample has left the output register
                if (status.pipe_idle)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
